FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL, included by bpa_engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define BPA_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Clocked property, checked during reset as well
`define BPA_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

FILE: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and types of the bitmap page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    // Geometry (BLOCK_COUNT is a multiple of WORD_BITS, powers of two)
    localparam int BLOCK_BYTES      = 4096;
    localparam int BLOCK_COUNT      = 8192;
    localparam int FIRST_FREE_BLOCK = 256;

    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = BLOCK_COUNT / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_AW    = $clog2(NUM_WORDS);
    localparam int WPTR_W     = WORD_AW + 1;
    localparam int BLK_W      = WORD_AW + BIT_W;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int FIRST_WORD = FIRST_FREE_BLOCK / WORD_BITS;
    localparam bit ALLOC_NONE = (FIRST_FREE_BLOCK >= BLOCK_COUNT);

    // Field widths
    localparam int DATA_W   = 32;
    localparam int KBLK_W   = DATA_W - BLOCK_SHIFT;
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 25;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

    // Register index (paddr[2])
    localparam logic REG_KSTART = 1'b0;
    localparam logic REG_KEND   = 1'b1;

    // Configuration seen by the engine
    typedef struct packed {
        logic [DATA_W-1:0] kstart;
        logic [DATA_W-1:0] kend;
    } cfg_t;

endpackage

`default_nettype wire

FILE: sv/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_if
// Valid/ready channels for operation requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_op_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::OP_W-1:0]     operation;
    logic [bpa_pkg::DATA_W-1:0]   free_addr;

    modport source (output valid, output operation, output free_addr, input ready);
    modport sink   (input valid, input operation, input free_addr, output ready);
endinterface

interface bpa_res_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::ADDR_W-1:0]   block_addr;
    logic [bpa_pkg::STATUS_W-1:0] status;

    modport source (output valid, output block_addr, output status, input ready);
    modport sink   (input valid, input block_addr, input status, output ready);
endinterface

`default_nettype wire

FILE: sv/bpa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bpa_bitmap_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_bitmap_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/bpa_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpa_cfg_regs
// APB register file: kernel start and end byte addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bpa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [bpa_pkg::DATA_W-1:0]   pwdata,
    output      logic [bpa_pkg::DATA_W-1:0]   prdata,
    output      logic                         pready,
    output      bpa_pkg::cfg_t                cfg
);

    logic [bpa_pkg::DATA_W-1:0] kstart_reg, kstart_next;
    logic [bpa_pkg::DATA_W-1:0] kend_reg, kend_next;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // write decode
    always_comb
    begin
        kstart_next = kstart_reg;
        kend_next   = kend_reg;
        if (wr_en)
        begin
            case (paddr[2])
                bpa_pkg::REG_KSTART: kstart_next = pwdata;
                bpa_pkg::REG_KEND:   kend_next   = pwdata;
                default:             kstart_next = kstart_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kstart_reg <= '0;
            kend_reg   <= '0;
        end
        else
        begin
            kstart_reg <= kstart_next;
            kend_reg   <= kend_next;
        end
    end

    // read mux
    always_comb
    begin
        case (paddr[2])
            bpa_pkg::REG_KSTART: prdata = kstart_reg;
            bpa_pkg::REG_KEND:   prdata = kend_reg;
            default:             prdata = '0;
        endcase
    end

    assign cfg.kstart = kstart_reg;
    assign cfg.kend   = kend_reg;

endmodule

`default_nettype wire

FILE: sv/bpa_engine.sv
// ----------------------------------------------------------------------------
// bpa_engine
// Operation sequencer: init walk, first-fit scan, free read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpa_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    bpa_op_if.sink               op,
    bpa_res_if.source            res,
    input  wire bpa_pkg::cfg_t   cfg
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_FREE_WR = 5'b00100,
        ST_INIT    = 5'b01000,
        ST_RESP    = 5'b10000
    } state_t;

    localparam int WB = bpa_pkg::WORD_BITS;

    state_t                           state_reg, state_next;
    logic [bpa_pkg::WPTR_W-1:0]       ptr_reg, ptr_next;
    logic [bpa_pkg::WORD_AW-1:0]      chk_reg, chk_next;
    logic [bpa_pkg::BIT_W-1:0]        bit_reg, bit_next;
    logic [bpa_pkg::ADDR_W-1:0]       pend_addr_reg, pend_addr_next;
    logic [bpa_pkg::STATUS_W-1:0]     pend_status_reg, pend_status_next;
    logic                             out_valid_reg, out_valid_next;
    logic [bpa_pkg::ADDR_W-1:0]       out_addr_reg, out_addr_next;
    logic [bpa_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [bpa_pkg::NUM_WORDS-1:0]    word_vld_reg, word_vld_next;

    // RAM port signals
    logic                             ram_we;
    logic [bpa_pkg::WORD_AW-1:0]      ram_waddr;
    logic [WB-1:0]                    ram_wdata;
    logic                             ram_re;
    logic [bpa_pkg::WORD_AW-1:0]      ram_raddr;
    logic [WB-1:0]                    ram_rdata;

    logic                             accept;
    logic [WB-1:0]                    rd_word;
    logic [WB-1:0]                    low_mask;
    logic [WB-1:0]                    eff_word;
    logic                             found;
    logic [bpa_pkg::BIT_W-1:0]        found_bit;
    logic [WB-1:0]                    found_onehot;
    logic [WB-1:0]                    free_onehot;
    logic [bpa_pkg::BLK_W+bpa_pkg::BLOCK_SHIFT-1:0] found_byte;

    logic [bpa_pkg::KBLK_W-1:0]       kfirst;
    logic [bpa_pkg::KBLK_W:0]         klimit;
    logic                             kern_any;
    logic                             kern_beyond;
    logic [WB-1:0]                    init_word;

    logic [bpa_pkg::KBLK_W-1:0]       fblk;
    logic                             free_beyond;

    bpa_bitmap_ram #(
        .DEPTH (bpa_pkg::NUM_WORDS),
        .WIDTH (WB)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = op.valid && op.ready;
    assign op.ready  = (state_reg == ST_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.block_addr = out_addr_reg;
    assign res.status     = out_status_reg;

    // never-written words read as all occupied
    assign rd_word = word_vld_reg[chk_reg] ? ram_rdata : '1;

    // blocks below the reserved boundary are never handed out
    always_comb
    begin
        for (int i = 0; i < WB; i++)
        begin
            low_mask[i] = ({chk_reg, bpa_pkg::BIT_W'(i)} < bpa_pkg::FIRST_FREE_BLOCK);
        end
    end
    assign eff_word = rd_word | low_mask;

    // lowest free bit of the word under test
    always_comb
    begin
        found     = 1'b0;
        found_bit = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (!eff_word[i])
            begin
                found     = 1'b1;
                found_bit = bpa_pkg::BIT_W'(i);
            end
        end
    end
    assign found_onehot = WB'(1) << found_bit;
    assign free_onehot  = WB'(1) << bit_reg;
    assign found_byte   = {chk_reg, found_bit, {bpa_pkg::BLOCK_SHIFT{1'b0}}};

    // kernel block range [kfirst, klimit)
    assign kfirst      = cfg.kstart[bpa_pkg::DATA_W-1:bpa_pkg::BLOCK_SHIFT];
    assign klimit      = {1'b0, cfg.kend[bpa_pkg::DATA_W-1:bpa_pkg::BLOCK_SHIFT]}
                         + {{bpa_pkg::KBLK_W{1'b0}}, 1'b1};
    assign kern_any    = ({1'b0, kfirst} < klimit);
    assign kern_beyond = kern_any && (klimit > bpa_pkg::BLOCK_COUNT);

    // init image of the word at ptr_reg
    always_comb
    begin
        logic [bpa_pkg::KBLK_W:0] g;
        for (int i = 0; i < WB; i++)
        begin
            g = (bpa_pkg::KBLK_W + 1)'({ptr_reg[bpa_pkg::WORD_AW-1:0],
                                         bpa_pkg::BIT_W'(i)});
            init_word[i] = (g < bpa_pkg::FIRST_FREE_BLOCK)
                           || (kern_any && (g >= {1'b0, kfirst}) && (g < klimit));
        end
    end

    // free address decode
    assign fblk        = op.free_addr[bpa_pkg::DATA_W-1:bpa_pkg::BLOCK_SHIFT];
    assign free_beyond = (fblk >= bpa_pkg::BLOCK_COUNT);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        chk_next         = chk_reg;
        bit_next         = bit_reg;
        pend_addr_next   = pend_addr_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        out_addr_next    = out_addr_reg;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = chk_reg;
        ram_wdata        = rd_word;
        ram_re           = 1'b0;
        ram_raddr        = chk_reg;

        // result slot drains independently of the sequencer
        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_addr_next   = '0;
                    pend_status_next = bpa_pkg::ST_OK;
                    case (op.operation)
                        bpa_pkg::OP_INIT:
                        begin
                            ptr_next   = '0;
                            state_next = ST_INIT;
                            if (kern_beyond)
                            begin
                                pend_status_next = bpa_pkg::ST_BEYOND;
                            end
                        end
                        bpa_pkg::OP_ALLOC:
                        begin
                            if (bpa_pkg::ALLOC_NONE)
                            begin
                                pend_status_next = bpa_pkg::ST_OOM;
                                state_next       = ST_RESP;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = bpa_pkg::WORD_AW'(bpa_pkg::FIRST_WORD);
                                chk_next   = bpa_pkg::WORD_AW'(bpa_pkg::FIRST_WORD);
                                ptr_next   = bpa_pkg::WPTR_W'(bpa_pkg::FIRST_WORD + 1);
                                state_next = ST_SCAN;
                            end
                        end
                        bpa_pkg::OP_FREE:
                        begin
                            if (free_beyond)
                            begin
                                pend_status_next = bpa_pkg::ST_BEYOND;
                                state_next       = ST_RESP;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = fblk[bpa_pkg::BLK_W-1:bpa_pkg::BIT_W];
                                chk_next   = fblk[bpa_pkg::BLK_W-1:bpa_pkg::BIT_W];
                                bit_next   = fblk[bpa_pkg::BIT_W-1:0];
                                state_next = ST_FREE_WR;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (found)
                begin
                    ram_we           = 1'b1;
                    ram_wdata        = rd_word | found_onehot;
                    pend_addr_next   = bpa_pkg::ADDR_W'(found_byte);
                    pend_status_next = bpa_pkg::ST_OK;
                    state_next       = ST_RESP;
                end
                else if (ptr_reg == bpa_pkg::NUM_WORDS)
                begin
                    pend_addr_next   = '0;
                    pend_status_next = bpa_pkg::ST_OOM;
                    state_next       = ST_RESP;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[bpa_pkg::WORD_AW-1:0];
                    chk_next  = ptr_reg[bpa_pkg::WORD_AW-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                end
            end

            ST_FREE_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = rd_word & ~free_onehot;
                state_next = ST_RESP;
            end

            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[bpa_pkg::WORD_AW-1:0];
                ram_wdata = init_word;
                if (ptr_reg == bpa_pkg::NUM_WORDS - 1)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = pend_addr_reg;
                    out_status_next = pend_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // per-word written marks
    always_comb
    begin
        word_vld_next = word_vld_reg;
        if (ram_we)
        begin
            word_vld_next[ram_waddr] = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            word_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            word_vld_reg  <= word_vld_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        chk_reg         <= chk_next;
        bit_reg         <= bit_next;
        pend_addr_reg   <= pend_addr_next;
        pend_status_reg <= pend_status_next;
        out_addr_reg    <= out_addr_next;
        out_status_reg  <= out_status_next;
    end

    // checks
    `BPA_ASSERT(a_scan_ptr, clk, rst_n, (state_reg == ST_SCAN) |-> (ptr_reg == ({1'b0, chk_reg} + 1'b1)))
    `BPA_ASSERT(a_we_busy, clk, rst_n, ram_we |-> ((state_reg != ST_IDLE) && (state_reg != ST_RESP)))
    `BPA_ASSERT(a_res_from_resp, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
    `BPA_ASSERT(a_accept_leaves_idle, clk, rst_n, accept |=> (state_reg != ST_IDLE))

endmodule

`default_nettype wire

FILE: sv/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical block allocator over a one-bit-per-block bitmap.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        beat contents
//  op       in   valid/ready      operation, free_addr
//  res      out  valid/ready      block_addr, status
//  apb      in   psel/penable     kernel_start_addr (0x0), kernel_end_addr (0x4)
//
//  Bitmap lives in a 256 x 32 RAM, one word per cycle through the RAM port.
//  init: one write per word; free: read, then write, then result;
//  alloc: reads words from the boundary at word 8 up to a free bit or the last word.
//  Reset clears per-word written marks; an unwritten word reads all occupied.
//  A finished result sits in an output register; the next beat is taken
//  while it waits, and the engine holds its next result until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    bpa_op_if.sink                            op,
    bpa_res_if.source                         res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bpa_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [bpa_pkg::DATA_W-1:0]   pwdata,
    output      logic [bpa_pkg::DATA_W-1:0]   prdata,
    output      logic                         pready
);

    bpa_pkg::cfg_t cfg;

    bpa_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpa_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .res   (res),
        .cfg   (cfg)
    );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap page allocator. A directed table walks
// the edge cases (reset bitmap, frees past RAM, kernel ranges that are empty
// or run past RAM, full memory). Random phases follow with low-memory and
// roomy kernel layouts under several idle/stall patterns. Every result beat
// is checked against the directed table or an in-bench bitmap predictor.
// ----------------------------------------------------------------------------

module testbench;
    import bpa_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 85;
    localparam int RAM_BYTES     = BLOCK_COUNT * BLOCK_BYTES;

    typedef struct packed {
        logic [ADDR_W-1:0]   block_addr;
        logic [STATUS_W-1:0] status;
    } result_t;

    // One row of the directed table: either a register write or an op beat
    typedef struct packed {
        bit          is_reg;
        logic        reg_sel;
        logic [1:0]  op;
        logic [31:0] value;
        bit          typed;
        result_t     want;
    } dir_row_t;

    localparam int DIRECTED_ROWS = 31;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        // fresh bitmap: everything occupied
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b1, '{25'h0, ST_OOM}},
        '{1'b0, 1'b0, OP_NOP,   32'hFFFF_FFFF, 1'b1, '{25'h0, ST_OK}},
        // block below the boundary is freed but never handed out
        '{1'b0, 1'b0, OP_FREE,  32'h0000_0000, 1'b1, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b1, '{25'h0, ST_OOM}},
        // frees past the top of RAM
        '{1'b0, 1'b0, OP_FREE,  32'hFFFF_FFFF, 1'b1, '{25'h0, ST_BEYOND}},
        '{1'b0, 1'b0, OP_FREE,  32'h0200_0000, 1'b1, '{25'h0, ST_BEYOND}},
        // default kernel: block 0 only
        '{1'b0, 1'b0, OP_INIT,  32'h0000_0000, 1'b1, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b1, '{25'h010_0000, ST_OK}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b1, '{25'h010_1000, ST_OK}},
        '{1'b0, 1'b0, OP_FREE,  32'h01FF_FFFF, 1'b1, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_FREE,  32'h0010_0ABC, 1'b1, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b0, '{25'h0, ST_OK}},
        // kernel right on the boundary
        '{1'b1, REG_KSTART, OP_NOP, 32'h0010_0000, 1'b0, '{25'h0, ST_OK}},
        '{1'b1, REG_KEND,   OP_NOP, 32'h001F_FFFF, 1'b0, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_INIT,  32'h0000_0000, 1'b1, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b1, '{25'h020_0000, ST_OK}},
        // end below start: empty kernel
        '{1'b1, REG_KSTART, OP_NOP, 32'h0020_0000, 1'b0, '{25'h0, ST_OK}},
        '{1'b1, REG_KEND,   OP_NOP, 32'h0010_0000, 1'b0, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_INIT,  32'h0000_0000, 1'b1, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b1, '{25'h010_0000, ST_OK}},
        // kernel covers all of RAM and runs past it
        '{1'b1, REG_KSTART, OP_NOP, 32'h0000_0000, 1'b0, '{25'h0, ST_OK}},
        '{1'b1, REG_KEND,   OP_NOP, 32'hFFFF_FFFF, 1'b0, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_INIT,  32'h0000_0000, 1'b1, '{25'h0, ST_BEYOND}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b1, '{25'h0, ST_OOM}},
        '{1'b0, 1'b0, OP_FREE,  32'h01FF_F000, 1'b1, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b1, '{25'h1FF_F000, ST_OK}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b1, '{25'h0, ST_OOM}},
        // kernel entirely past RAM: nothing marked, still flagged
        '{1'b1, REG_KSTART, OP_NOP, 32'hFFFF_FFFF, 1'b0, '{25'h0, ST_OK}},
        '{1'b0, 1'b0, OP_INIT,  32'h0000_0000, 1'b1, '{25'h0, ST_BEYOND}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b1, '{25'h010_0000, ST_OK}},
        '{1'b0, 1'b0, OP_ALLOC, 32'h0000_0000, 1'b0, '{25'h0, ST_OK}}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    wire  [DATA_W-1:0]   prdata;
    wire                 pready;

    bpa_op_if  op_ch ();
    bpa_res_if res_ch ();

    bitmap_page_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: occupancy per block plus the kernel registers
    bit          block_busy [BLOCK_COUNT];
    logic [31:0] kernel_start;
    logic [31:0] kernel_end;

    result_t     awaited_outcomes [$];
    logic [31:0] held_blocks [$];
    result_t     oldest_outcome;

    int   error_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic holding;
    event hold_start;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR cycle %0d: %s got 0x%08h expected 0x%08h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Bitmap predictor: applies one op and returns the result beat it causes
    function automatic result_t bitmap_outcome(input logic [1:0] op,
                                               input logic [31:0] addr);
        result_t outcome;
        int      kfirst;
        int      klimit;
        int      blk;
        bit      found;
        outcome = '0;
        found   = 1'b0;
        case (op)
            OP_INIT:
            begin
                for (int i = 0; i < BLOCK_COUNT; i++)
                    block_busy[i] = (i < FIRST_FREE_BLOCK);
                kfirst = int'(kernel_start >> BLOCK_SHIFT);
                klimit = int'(kernel_end >> BLOCK_SHIFT) + 1;
                if (kfirst < klimit)
                begin
                    if (klimit > BLOCK_COUNT)
                    begin
                        outcome.status = ST_BEYOND;
                        klimit = BLOCK_COUNT;
                    end
                    for (int i = kfirst; i < klimit; i++)
                        block_busy[i] = 1'b1;
                end
            end
            OP_ALLOC:
            begin
                outcome.status = ST_OOM;
                for (int i = FIRST_FREE_BLOCK; i < BLOCK_COUNT && !found; i++)
                begin
                    if (!block_busy[i])
                    begin
                        block_busy[i]      = 1'b1;
                        outcome.block_addr = ADDR_W'(i * BLOCK_BYTES);
                        outcome.status     = ST_OK;
                        found              = 1'b1;
                    end
                end
            end
            OP_FREE:
            begin
                blk = int'(addr >> BLOCK_SHIFT);
                if (blk >= BLOCK_COUNT)
                    outcome.status = ST_BEYOND;
                else
                    block_busy[blk] = 1'b0;
            end
            default: ;
        endcase
        return outcome;
    endfunction

    // Offer one op beat, wait for acceptance, record what should come back
    task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                             input bit typed, input result_t want);
        result_t predicted;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            op_ch.valid <= 1'b0;
            @(posedge clk);
        end
        op_ch.valid     <= 1'b1;
        op_ch.operation <= op;
        op_ch.free_addr <= addr;
        do @(posedge clk); while (!op_ch.ready);
        predicted = bitmap_outcome(op, addr);
        awaited_outcomes.push_back(typed ? want : predicted);
        if (op == OP_INIT)
            held_blocks.delete();
        else if (op == OP_ALLOC && predicted.status == ST_OK)
            held_blocks.push_back(32'(predicted.block_addr));
    endtask

    // Register write with readback, only once the engine has gone quiet
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        op_ch.valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // read back: straight into the next setup cycle
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
            report_mismatch("register readback", prdata, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_KSTART)
            kernel_start = value;
        else
            kernel_end = value;
    endtask

    // One random phase: kernel layout, init, then a mix of ops
    task automatic run_phase(input int gap_pct, input int stall_pct, input bit tight,
                             input bit squeeze, input int items);
        logic [31:0] kstart;
        logic [31:0] kend;
        logic [31:0] addr;
        int          pick;
        int          idx;
        int          free_top;
        result_t     no_want;
        no_want = '0;
        if (tight)
        begin
            // kernel swallows nearly all RAM; a few blocks stay free at the top
            free_top = $urandom_range(1, 40);
            kstart   = $urandom_range(0, FIRST_FREE_BLOCK * BLOCK_BYTES - 1);
            kend     = (BLOCK_COUNT - free_top) * BLOCK_BYTES - 1;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    kstart = $urandom_range(0, 32'h0040_0000);
                    kend   = kstart + $urandom_range(0, 32'h0040_0000);
                end
                1:
                begin
                    kstart = $urandom;
                    kend   = $urandom;
                end
                2:
                begin
                    kstart = 32'h0;
                    kend   = 32'h0;
                end
                default:
                begin
                    kstart = $urandom_range(0, RAM_BYTES - 1);
                    kend   = 32'hFFFF_FFFF;
                end
            endcase
        end
        write_register(REG_KSTART, kstart);
        write_register(REG_KEND, kend);
        send_idle_pct  = gap_pct;
        recv_stall_pct = stall_pct;
        send_item(OP_INIT, $urandom, 1'b0, no_want);
        if (squeeze)
            -> hold_start;
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_item(OP_ALLOC, $urandom, 1'b0, no_want);
            else if (pick < 78 && held_blocks.size() != 0)
            begin
                idx  = $urandom_range(0, held_blocks.size() - 1);
                addr = held_blocks[idx] | $urandom_range(0, BLOCK_BYTES - 1);
                held_blocks.delete(idx);
                send_item(OP_FREE, addr, 1'b0, no_want);
            end
            else if (pick < 86)
                send_item(OP_FREE, $urandom, 1'b0, no_want);
            else if (pick < 93)
                send_item(OP_FREE, $urandom_range(0, RAM_BYTES - 1), 1'b0, no_want);
            else if (pick < 97)
                send_item(OP_NOP, $urandom, 1'b0, no_want);
            else
                send_item(OP_INIT, $urandom, 1'b0, no_want);
        end
    endtask

    // Long receiver hold-off, counted here
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_start);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    // Result side: check each accepted beat, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_outcomes.size() == 0)
                report_mismatch("result beat with nothing awaited",
                                32'(res_ch.block_addr), 32'h0);
            else
            begin
                oldest_outcome = awaited_outcomes.pop_front();
                if (res_ch.block_addr !== oldest_outcome.block_addr)
                    report_mismatch("block_addr", 32'(res_ch.block_addr),
                                    32'(oldest_outcome.block_addr));
                if (res_ch.status !== oldest_outcome.status)
                    report_mismatch("status", 32'(res_ch.status),
                                    32'(oldest_outcome.status));
            end
        end
        res_ch.ready <= !holding && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Stimulus
    initial
    begin
        dir_row_t row;
        error_count        = 0;
        cycle_count        = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        kernel_start       = 32'h0;
        kernel_end         = 32'h0;
        for (int i = 0; i < BLOCK_COUNT; i++)
            block_busy[i] = 1'b1;
        rst_n              = 1'b0;
        op_ch.valid        = 1'b0;
        op_ch.operation    = OP_NOP;
        op_ch.free_addr    = 32'h0;
        res_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = 32'h0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            row = directed_rows[k];
            if (row.is_reg)
                write_register(row.reg_sel, row.value);
            else
                send_item(row.op, row.value, row.typed, row.want);
        end

        // random phases: no idling, sender gaps, receiver stalls, both
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0: run_phase(0, 0, p[0], p == 0, PHASE_ITEMS);
                1: run_phase(69, 0, p[0], 1'b0, PHASE_ITEMS);
                2: run_phase(0, 69, p[0], 1'b0, PHASE_ITEMS);
                default: run_phase(35, 35, p[0], 1'b0, PHASE_ITEMS);
            endcase
        end

        // drain
        op_ch.valid   <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
